// ----- rtl/itsm_pkg.sv -----
// Shared constants, types and functions for the IPv4 text SHA-256 matcher.
package itsm_pkg;

	localparam int NumRounds = 64;
	localparam int NumTargetWords = 4;
	localparam int AddrW = 5;

	// Register byte addresses
	localparam logic [AddrW-1:0] RegTarget0 = 5'd0;
	localparam logic [AddrW-1:0] RegTarget1 = 5'd8;
	localparam logic [AddrW-1:0] RegTarget2 = 5'd16;
	localparam logic [AddrW-1:0] RegTarget3 = 5'd24;

	// Working variables a..h
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
		logic [31:0] f;
		logic [31:0] g;
		logic [31:0] h;
	} work_t;

	// Side data that rides along the pipeline
	typedef struct packed {
		logic        vld;
		logic [31:0] addr;
		logic [3:0]  len;
	} tag_t;

	localparam logic [255:0] InitH = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	// Octet to three ASCII digits plus digit count
	function automatic logic [25:0] octet_text(input logic [7:0] v);
		logic [3:0] hd;
		logic [3:0] td;
		logic [3:0] od;
		logic [7:0] r;
		logic [1:0] n;
		hd = (v >= 8'd200) ? 4'd2 : ((v >= 8'd100) ? 4'd1 : 4'd0);
		r = v - 8'({4'h0, hd} * 8'd100);
		// tens by reciprocal multiply, exact for r below 180
		td = 4'(({8'h00, r} * 16'd205) >> 11);
		od = 4'(r - 8'({4'h0, td} * 8'd10));
		n = (v >= 8'd100) ? 2'd3 : ((v >= 8'd10) ? 2'd2 : 2'd1);
		return {n, 8'h30 | {4'h0, hd}, 8'h30 | {4'h0, td}, 8'h30 | {4'h0, od}};
	endfunction

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- rtl/itsm_msg.sv -----
// Builds the padded 16-word message block from an address.
module itsm_msg (
	input  logic [31:0]  addr,
	output logic [511:0] block,
	output logic [3:0]   len
);
	import itsm_pkg::*;

	logic [25:0]  oct [4];
	logic [7:0]   buf_b [64];
	logic [1:0]   n;
	logic [5:0]   base;

	always_comb begin
		for (int i = 0; i < 64; i++) buf_b[i] = 8'h00;
		for (int i = 0; i < 4; i++) oct[i] = octet_text(addr[31-8*i -: 8]);
		base = 6'd0;
		for (int i = 0; i < 4; i++) begin
			n = oct[i][25:24];
			// digits, most significant first
			if (n == 2'd3) begin
				buf_b[base] = oct[i][23:16];
				buf_b[base+6'd1] = oct[i][15:8];
				buf_b[base+6'd2] = oct[i][7:0];
			end else if (n == 2'd2) begin
				buf_b[base] = oct[i][15:8];
				buf_b[base+6'd1] = oct[i][7:0];
			end else begin
				buf_b[base] = oct[i][7:0];
			end
			base = base + {4'b0000, n};
			if (i < 3) begin
				buf_b[base] = 8'h2e;
				base = base + 6'd1;
			end
		end
		len = base[3:0];
		buf_b[base] = 8'h80;
		// bit length is at most 120, so it fits the last byte
		buf_b[63] = {base[4:0], 3'b000};
		for (int i = 0; i < 64; i++) block[511-8*i -: 8] = buf_b[i];
	end
endmodule

// ----- rtl/itsm_cell.sv -----
// One SHA-256 round cell: compression round plus rolling 16-word schedule.
module itsm_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [5:0]           rnd,
	input  itsm_pkg::work_t      work_in,
	input  logic [511:0]         sched_in,
	input  itsm_pkg::tag_t       tag_in,
	output itsm_pkg::work_t      work_out,
	output logic [511:0]         sched_out,
	output itsm_pkg::tag_t       tag_out
);
	import itsm_pkg::*;

	logic [31:0] w0, w1, w9, w14, s0, s1, wn;
	logic [31:0] bs1, ch, t1, bs0, mj;
	work_t       nxt;
	work_t       work_q;
	logic [511:0] sched_q;
	logic        vld_q;
	logic [31:0] addr_q;
	logic [3:0]  len_q;

	// Round logic; schedule word 0 is consumed, a new word 16 is appended
	always_comb begin
		w0 = sched_in[511:480];
		w1 = sched_in[479:448];
		w9 = sched_in[223:192];
		w14 = sched_in[63:32];
		s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		wn = w0 + s0 + w9 + s1;
		bs1 = rotr(work_in.e, 6) ^ rotr(work_in.e, 11) ^ rotr(work_in.e, 25);
		ch = (work_in.e & work_in.f) ^ (~work_in.e & work_in.g);
		t1 = work_in.h + bs1 + ch + round_k(rnd) + w0;
		bs0 = rotr(work_in.a, 2) ^ rotr(work_in.a, 13) ^ rotr(work_in.a, 22);
		mj = (work_in.a & work_in.b) ^ (work_in.a & work_in.c) ^ (work_in.b & work_in.c);
		nxt.h = work_in.g;
		nxt.g = work_in.f;
		nxt.f = work_in.e;
		nxt.e = work_in.d + t1;
		nxt.d = work_in.c;
		nxt.c = work_in.b;
		nxt.b = work_in.a;
		nxt.a = t1 + bs0 + mj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= tag_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_q <= nxt;
			sched_q <= {sched_in[479:0], wn};
			addr_q <= tag_in.addr;
			len_q <= tag_in.len;
		end
	end

	assign work_out = work_q;
	assign sched_out = sched_q;
	assign tag_out = {vld_q, addr_q, len_q};
endmodule

// ----- rtl/ipv4_text_sha256_match.sv -----
// Top level: APB target registers, text builder, 64-cell round chain, compare.
//
//  channel    | handshake                     | payload
//  -----------+-------------------------------+---------------------------------------
//  input      | valid / ready                 | candidate_address
//  output     | out_valid / out_ready         | tested_address, text_length, hash_match
//  config     | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One address enters per clock while not stalled; each result passes the text stage,
// 64 round cells and the digest compare stage. Rate is set by the round chain,
// one cell per SHA-256 round. The whole chain advances together: when the
// output register holds an untaken result, the chain stalls and ready drops.
// Reset clears valid flags and target words; no clearing pass.
module ipv4_text_sha256_match (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [31:0] candidate_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] tested_address,
	output logic [3:0]  text_length,
	output logic        hash_match,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	import itsm_pkg::*;

	logic [63:0]  target_q [NumTargetWords];
	logic         adv;
	logic [511:0] blk;
	logic [3:0]   blen;
	logic [511:0] sched_s1;
	logic         vld_s1;
	logic [31:0]  addr_s1;
	logic [3:0]   len_s1;
	tag_t         tag_s1;
	work_t        work_c [NumRounds+1];
	logic [511:0] sched_c [NumRounds+1];
	tag_t         tag_c [NumRounds+1];
	logic [255:0] dig;
	logic         out_vld_q;
	logic [31:0]  out_addr_q;
	logic [3:0]   out_len_q;
	logic         out_match_q;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumTargetWords; i++) target_q[i] <= 64'd0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				RegTarget0: target_q[0] <= pwdata;
				RegTarget1: target_q[1] <= pwdata;
				RegTarget2: target_q[2] <= pwdata;
				RegTarget3: target_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr)
			RegTarget0: prdata = target_q[0];
			RegTarget1: prdata = target_q[1];
			RegTarget2: prdata = target_q[2];
			RegTarget3: prdata = target_q[3];
			default: prdata = 64'd0;
		endcase
	end

	// Whole pipe moves unless the output holds a result not taken
	assign adv = !out_vld_q || out_ready;
	assign ready = adv;

	// Text and padding stage
	itsm_msg u_msg (.addr(candidate_address), .block(blk), .len(blen));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sched_s1 <= blk;
			addr_s1 <= candidate_address;
			len_s1 <= blen;
		end
	end

	assign tag_s1 = {vld_s1, addr_s1, len_s1};
	assign work_c[0] = work_t'(InitH);
	assign sched_c[0] = sched_s1;
	assign tag_c[0] = tag_s1;

	// Round chain
	for (genvar r = 0; r < NumRounds; r++) begin : g_round
		itsm_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(adv), .rnd(6'(r)),
			.work_in(work_c[r]), .sched_in(sched_c[r]), .tag_in(tag_c[r]),
			.work_out(work_c[r+1]), .sched_out(sched_c[r+1]), .tag_out(tag_c[r+1]));
	end

	// Final add and compare
	always_comb begin
		dig[255:224] = InitH[255:224] + work_c[NumRounds].a;
		dig[223:192] = InitH[223:192] + work_c[NumRounds].b;
		dig[191:160] = InitH[191:160] + work_c[NumRounds].c;
		dig[159:128] = InitH[159:128] + work_c[NumRounds].d;
		dig[127:96]  = InitH[127:96]  + work_c[NumRounds].e;
		dig[95:64]   = InitH[95:64]   + work_c[NumRounds].f;
		dig[63:32]   = InitH[63:32]   + work_c[NumRounds].g;
		dig[31:0]    = InitH[31:0]    + work_c[NumRounds].h;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= tag_c[NumRounds].vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_addr_q <= tag_c[NumRounds].addr;
			out_len_q <= tag_c[NumRounds].len;
			out_match_q <= (dig == {target_q[0], target_q[1], target_q[2], target_q[3]});
		end
	end

	assign out_valid = out_vld_q;
	assign tested_address = out_addr_q;
	assign text_length = out_len_q;
	assign hash_match = out_match_q;
endmodule

// ----- rtl/itsm_check.sv -----
// Port-level checker for the matcher, bound to the top level.
module itsm_check (
	input logic        clk,
	input logic        arst_n,
	input logic        ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] tested_address,
	input logic [3:0]  text_length,
	input logic        pready
);
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (text_length >= 4'd7 && text_length <= 4'd15))
		else $error("text length out of range");
	a_stall_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !ready)
		else $error("ready while output stalled");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(tested_address)))
		else $error("result dropped while stalled");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
endmodule

bind ipv4_text_sha256_match itsm_check u_check (
	.clk(clk), .arst_n(arst_n), .ready(ready),
	.out_valid(out_valid), .out_ready(out_ready), .tested_address(tested_address),
	.text_length(text_length), .pready(pready));

// ----- bench/tb_checker.sv -----
// Result checker for the IPv4 text SHA-256 matcher: predicts each result and compares it.
module tb_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid,
	input  logic         ready,
	input  logic [31:0]  candidate_address,
	input  logic         out_valid,
	input  logic         out_ready,
	input  logic [31:0]  tested_address,
	input  logic [3:0]   text_length,
	input  logic         hash_match,
	input  logic [255:0] target_digest,
	output int           fail_count,
	output int           pending_count,
	output int           match_count
);

	typedef struct packed {
		logic [31:0] addr;
		logic [3:0]  len;
		logic        hit;
	} verdict_t;

	verdict_t verdict_q[$];

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	localparam logic [31:0] StartH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Dotted-decimal text of an address as one padded block
	function automatic logic [511:0] text_block(input logic [31:0] addr,
		output logic [3:0] len);
		logic [7:0]   msg [64];
		logic [511:0] blk;
		int           pos, oct;
		pos = 0;
		for (int i = 0; i < 64; i++) msg[i] = 8'h00;
		for (int k = 3; k >= 0; k--) begin
			oct = int'((addr >> (8 * k)) & 32'hff);
			if (oct >= 100) begin
				msg[pos] = 8'(8'h30 + oct / 100); pos++;
			end
			if (oct >= 10) begin
				msg[pos] = 8'(8'h30 + (oct / 10) % 10); pos++;
			end
			msg[pos] = 8'(8'h30 + oct % 10); pos++;
			if (k != 0) begin
				msg[pos] = 8'h2e; pos++;
			end
		end
		msg[pos] = 8'h80;
		msg[63] = 8'(pos * 8);
		for (int i = 0; i < 64; i++) blk[511 - 8*i -: 8] = msg[i];
		len = 4'(pos);
		return blk;
	endfunction

	// SHA-256 of one padded block
	function automatic logic [255:0] block_digest(input logic [511:0] blk);
		logic [31:0]  w [64];
		logic [31:0]  v [8];
		logic [31:0]  t1, t2;
		logic [255:0] dig;
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ w[i-7] + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		for (int i = 0; i < 8; i++) v[i] = StartH[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = StartH[i] + v[i];
		return dig;
	endfunction

	// Digest of an address's text, used by the bench to pick targets
	function automatic logic [255:0] address_digest(input logic [31:0] addr);
		logic [3:0]   len;
		logic [511:0] blk;
		blk = text_block(addr, len);
		return block_digest(blk);
	endfunction

	// Expected result for one request
	function automatic verdict_t hash_address(input logic [31:0] addr, input logic [255:0] tgt);
		logic [3:0]   len;
		logic [511:0] blk;
		verdict_t     r;
		blk = text_block(addr, len);
		r.addr = addr;
		r.len = len;
		r.hit = (block_digest(blk) == tgt);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		match_count = 0;
	end

	assign pending_count = verdict_q.size();

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n) begin
			if (valid && ready)
				verdict_q = {verdict_q, hash_address(candidate_address, target_digest)};
			if (out_valid && out_ready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("unexpected result", tested_address, 32'd0);
				end else begin
					want = verdict_q.pop_front();
					if (tested_address !== want.addr)
						report_mismatch("tested_address", tested_address, want.addr);
					if (text_length !== want.len)
						report_mismatch("text_length", {28'd0, text_length}, {28'd0, want.len});
					if (hash_match !== want.hit)
						report_mismatch("hash_match", {31'd0, hash_match}, {31'd0, want.hit});
					if (want.hit) match_count++;
				end
			end
		end
	end

endmodule

// ----- bench/tb.sv -----
// Top of the IPv4 text SHA-256 matcher bench: stimulus, register writes and verdict.
module tb;
	import itsm_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        valid = 0;
	logic        ready;
	logic [31:0] candidate_address = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [31:0] tested_address;
	logic [3:0]  text_length;
	logic        hash_match;
	logic        psel = 0, penable = 0, pwrite = 0;
	logic [4:0]  paddr = 0;
	logic [63:0] pwdata = 0;
	logic [63:0] prdata;
	logic        pready;

	logic [255:0] target_digest = '0;
	int           fail_count, pending_count, match_count;
	int           send_idle, recv_stall, requests_sent, target_sets;

	always #4 clk = ~clk;

	ipv4_text_sha256_match i_dut (.*);

	tb_checker i_chk (.*);

	// Receiver side stalls at the phase's rate
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall);

	task automatic write_target(input int idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; pwdata <= val;
		case (idx)
			0: paddr <= RegTarget0;
			1: paddr <= RegTarget1;
			2: paddr <= RegTarget2;
			default: paddr <= RegTarget3;
		endcase
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		target_digest[255 - 64*idx -: 64] = val;
	endtask

	task automatic set_target(input logic [255:0] t);
		for (int i = 0; i < NumTargetWords; i++) write_target(i, t[255 - 64*i -: 64]);
		target_sets++;
	endtask

	// Wait until every result is back, then drain the pipeline
	task automatic wait_idle();
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	// Sender idles with valid low, then holds the request until taken
	task automatic send_request(input logic [31:0] a);
		while ($urandom_range(99) < send_idle) begin
			valid <= 0;
			@(posedge clk);
		end
		valid <= 1;
		candidate_address <= a;
		@(posedge clk);
		while (!ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic end_burst();
		valid <= 0;
	endtask

	// Octets drawn by digit count, three-digit ones most often, so every text length appears
	function automatic logic [7:0] pick_octet();
		case ($urandom_range(3))
			0: return 8'($urandom_range(9));
			1: return 8'($urandom_range(99, 10));
			default: return 8'($urandom_range(255, 100));
		endcase
	endfunction

	function automatic logic [31:0] pick_address();
		if ($urandom_range(3) == 0) return $urandom;
		return {pick_octet(), pick_octet(), pick_octet(), pick_octet()};
	endfunction

	logic [31:0] hit_addr;

	initial begin
		send_idle = 0; recv_stall = 0; requests_sent = 0; target_sets = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// Directed: extreme octets and text lengths 7, 9 to 13 and 15, target left at zero
		send_request(32'h00000000);
		send_request(32'hffffffff);
		send_request(32'h0a0a0a0a);
		send_request(32'h09636409);
		send_request(32'h64096409);
		send_request(32'h00ff00ff);
		send_request(32'hff00ff00);
		send_request(32'h01020304);
		send_request(32'hc0a80001);
		send_request(32'h7f000001);
		send_request(32'h0aff0a63);
		send_request(32'h63640a09);
		send_request(32'h55aa55aa);
		send_request(32'haa55aa55);
		end_burst();
		wait_idle();

		// Clear the target; later phases learn digests from the checker's own model as targets
		hit_addr = 32'h0a000001;
		set_target(256'h0);
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 62; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 62; end
				default: begin send_idle = 6; recv_stall = 6; end
			endcase
			// New target each phase: all ones, random, known digests
			case (ph)
				0: set_target({256{1'b1}});
				1: set_target({$urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom});
				2: set_target(i_chk.address_digest(hit_addr));
				default: set_target(i_chk.address_digest(32'hffffffff));
			endcase
			if (ph == 2) begin
				send_request(hit_addr);
				send_request(hit_addr + 32'd1);
			end
			if (ph == 3) send_request(32'hffffffff);
			for (int n = 0; n < 200; n++) begin
				send_request(pick_address());
				// Hold off once until every result is back
				if (ph == 1 && n == 100) begin
					end_burst();
					@(posedge clk);
					while (pending_count != 0) @(posedge clk);
				end
			end
			end_burst();
			wait_idle();
		end

		$display("Sent %0d addresses under %0d targets, %0d digest matches seen.",
			requests_sent, target_sets, match_count);
		$display("Covered idle and stall phases, every text length and register.");
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#4000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
